// ===== rtl/core/typed_point_table_nearest_assert.svh =====
// Assertion macros shared by the typed point table RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef TYPED_POINT_TABLE_NEAREST_ASSERT_SVH
`define TYPED_POINT_TABLE_NEAREST_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent and consequent hold in the same cycle.
`define TPTN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("typed point table: same-cycle check failed");
// Consequent holds in the cycle after the antecedent.
`define TPTN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("typed point table: next-cycle check failed");
`else
`define TPTN_ASSERT_NOW(label, clk, rst, ante, cons)
`define TPTN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/tptn_pkg.sv =====
// Shared types and constants of the typed point table.
// Depends on nothing; used by the controller, the datapath and the top level.
package tptn_pkg;

   localparam int OP_W        = 2;
   localparam int KIND_W      = 2;
   localparam int LIMIT_W     = 22;
   localparam int RSP_INDEX_W = 6;
   localparam int RSP_COUNT_W = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 22'd999999;

   localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OP_W-1:0] OP_NEAREST = 2'd1;
   localparam logic [OP_W-1:0] OP_LOCATE  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // request accepted: capture it, do the insert
      logic scan_step;  // read the entry at the scan address and advance
      logic load_rsp;   // move the finished result into the output register
   } tptn_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_needed;  // offered request is a search over a non-empty table
      logic scan_last;    // scan address is the last stored entry
      logic pipe_busy;    // entries still in flight through the compare pipeline
      logic rsp_free;     // output register can take a result this cycle
   } tptn_status_type;

endpackage

// ===== rtl/core/tptn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tptn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tptn_ctrl.sv =====
// Controller state machine of the typed point table.
// Depends on tptn_pkg; drives the datapath through tptn_cmd_type.
module tptn_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tptn_pkg::tptn_status_type status,
   output tptn_pkg::tptn_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.scan_needed ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/tptn_datapath.sv =====
// Datapath of the typed point table: point store, scan pipeline, result registers.
// Depends on tptn_pkg and tptn_ram; commanded by tptn_ctrl.
module tptn_datapath #(
   parameter int TABLE_DEPTH = 64,
   parameter int COORD_BITS  = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tptn_pkg::tptn_cmd_type               cmd,
   output tptn_pkg::tptn_status_type            status,
   input  logic [tptn_pkg::OP_W-1:0]            req_op,
   input  logic [tptn_pkg::KIND_W-1:0]          req_kind,
   input  logic [COORD_BITS-1:0]                req_x_pos,
   input  logic [COORD_BITS-1:0]                req_y_pos,
   input  logic                                csr_write_enable,
   input  logic [tptn_pkg::LIMIT_W-1:0]         csr_write_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_success,
   output logic [tptn_pkg::RSP_INDEX_W-1:0]     rsp_result_index,
   output logic [tptn_pkg::RSP_COUNT_W-1:0]     rsp_entry_count
);

   localparam int ADDR_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int SQ_W      = 2 * COORD_BITS;
   localparam int DIST_W    = SQ_W + 1;
   localparam int BEST_W    = (DIST_W > tptn_pkg::LIMIT_W) ? DIST_W : tptn_pkg::LIMIT_W;
   localparam int ENTRY_W   = tptn_pkg::KIND_W + 2 * COORD_BITS;
   localparam int IDX_EXT_W = (ADDR_W > tptn_pkg::RSP_INDEX_W) ? ADDR_W
                                                               : tptn_pkg::RSP_INDEX_W;
   localparam int CNT_EXT_W = (CNT_W > tptn_pkg::RSP_COUNT_W) ? CNT_W
                                                             : tptn_pkg::RSP_COUNT_W;

   // Control registers.
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [tptn_pkg::LIMIT_W-1:0]     limit_ff, limit_in;
   logic                             v1_ff, v2_ff;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [tptn_pkg::OP_W-1:0]        op_ff;
   logic [tptn_pkg::KIND_W-1:0]      kind_ff;
   logic [COORD_BITS-1:0]            qx_ff, qy_ff;
   logic [ADDR_W-1:0]                addr_ff, addr_in;
   logic [ADDR_W-1:0]                idx1_ff, idx2_ff;
   logic [SQ_W-1:0]                  sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic                             kind_ok_ff, pos_eq_ff, kind_ok_in, pos_eq_in;
   logic [BEST_W-1:0]                best_ff, best_in;
   logic                             res_ok_ff, res_ok_in;
   logic [ADDR_W-1:0]                res_idx_ff, res_idx_in;
   logic                             rsp_success_ff;
   logic [tptn_pkg::RSP_INDEX_W-1:0] rsp_index_ff;
   logic [tptn_pkg::RSP_COUNT_W-1:0] rsp_count_ff;

   logic                             table_full;
   logic                             do_write;
   logic [ENTRY_W-1:0]               rd_data;
   logic [COORD_BITS-1:0]            rd_x, rd_y, dx, dy;
   logic [tptn_pkg::KIND_W-1:0]      rd_kind;
   logic [DIST_W-1:0]                dist_sum;
   logic                             near_hit, loc_hit;
   logic [IDX_EXT_W-1:0]             idx_ext;
   logic [CNT_EXT_W-1:0]             cnt_ext;

   assign table_full = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign do_write   = cmd.load && (req_op == tptn_pkg::OP_INSERT) && !table_full;

   tptn_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_points (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_kind, req_y_pos, req_x_pos}),
      .rd_en   (cmd.scan_step),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Stage 1: distance terms of the entry just read.
   assign rd_x    = rd_data[COORD_BITS-1:0];
   assign rd_y    = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign rd_kind = rd_data[ENTRY_W-1:2*COORD_BITS];

   always_comb begin
      dx         = (rd_x >= qx_ff) ? (rd_x - qx_ff) : (qx_ff - rd_x);
      dy         = (rd_y >= qy_ff) ? (rd_y - qy_ff) : (qy_ff - rd_y);
      sqx_in     = SQ_W'(dx) * SQ_W'(dx);
      sqy_in     = SQ_W'(dy) * SQ_W'(dy);
      kind_ok_in = (rd_kind == kind_ff);
      pos_eq_in  = (rd_x == qx_ff) && (rd_y == qy_ff);
   end

   // Stage 2: sum, compare and keep the winner.
   assign dist_sum = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   assign near_hit = v2_ff && (op_ff == tptn_pkg::OP_NEAREST) && kind_ok_ff
                     && (BEST_W'(dist_sum) < best_ff);
   assign loc_hit  = v2_ff && (op_ff == tptn_pkg::OP_LOCATE) && pos_eq_ff && !res_ok_ff;

   always_comb begin
      count_in   = count_ff;
      limit_in   = csr_write_enable ? csr_write_data : limit_ff;
      addr_in    = addr_ff;
      best_in    = best_ff;
      res_ok_in  = res_ok_ff;
      res_idx_in = res_idx_ff;
      if (cmd.load) begin
         addr_in    = '0;
         best_in    = BEST_W'(limit_ff);
         res_ok_in  = 1'b0;
         res_idx_in = '0;
         if (do_write) begin
            count_in   = count_ff + CNT_W'(1);
            res_ok_in  = 1'b1;
            res_idx_in = count_ff[ADDR_W-1:0];
         end
      end else begin
         if (cmd.scan_step) begin
            addr_in = addr_ff + ADDR_W'(1);
         end
         if (near_hit) begin
            best_in    = BEST_W'(dist_sum);
            res_ok_in  = 1'b1;
            res_idx_in = idx2_ff;
         end else if (loc_hit) begin
            res_ok_in  = 1'b1;
            res_idx_in = idx2_ff;
         end
      end
   end

   assign idx_ext = IDX_EXT_W'(res_idx_ff);
   assign cnt_ext = CNT_EXT_W'(count_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         limit_ff     <= tptn_pkg::LIMIT_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         v1_ff        <= cmd.scan_step;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         kind_ff <= req_kind;
         qx_ff   <= req_x_pos;
         qy_ff   <= req_y_pos;
      end
      addr_ff    <= addr_in;
      best_ff    <= best_in;
      res_ok_ff  <= res_ok_in;
      res_idx_ff <= res_idx_in;
      idx1_ff    <= addr_ff;
      idx2_ff    <= idx1_ff;
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
      kind_ok_ff <= kind_ok_in;
      pos_eq_ff  <= pos_eq_in;
      if (cmd.load_rsp) begin
         rsp_success_ff <= res_ok_ff;
         rsp_index_ff   <= res_ok_ff ? idx_ext[tptn_pkg::RSP_INDEX_W-1:0] : '0;
         rsp_count_ff   <= cnt_ext[tptn_pkg::RSP_COUNT_W-1:0];
      end
   end

   always_comb begin
      status.scan_needed = ((req_op == tptn_pkg::OP_NEAREST) ||
                            (req_op == tptn_pkg::OP_LOCATE)) && (count_ff != '0);
      status.scan_last   = (CNT_W'(addr_ff) == (count_ff - CNT_W'(1)));
      status.pipe_busy   = v1_ff || v2_ff;
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

// ===== rtl/core/typed_point_table_nearest.sv =====
// Typed point table with nearest-of-kind and exact-position search. A request carries an op,
// a kind and an (x, y) position. Insert appends the point at the next free index and fails
// once TABLE_DEPTH entries are stored. Nearest reports the index of the entry of the requested
// kind with the smallest squared Euclidean distance, if that distance is strictly below the
// distance limit register; ties go to the lower index. Locate reports the first index
// stored at exactly the requested position, of any kind. Every response carries the entry
// count after the request; success low means no entry was added or found, and the index is
// then zero. The op code three changes nothing and answers with success low. Requests are
// handled one at a time. An insert, an op code three or a search of an empty table goes
// from acceptance straight to the done state, which loads its response into the output
// register once that register is free; only then is the next request taken. A nearest or
// locate search first has the single read port of the point store visit the N stored
// entries, one entry per cycle, and then waits for the registered read, the two compare
// stages and the winner register to drain before the done state loads the response.
// A finished response waits in the output register, so the next request is accepted
// while it is still held.
// The distance limit is written through csr_write_enable and csr_write_data; the user must
// write it only while no request is in progress, which the block does not enforce. There is
// no clearing pass after reset: only stored entries are ever read.
// Depends on tptn_pkg, tptn_ctrl, tptn_datapath, tptn_ram and the assertion macro header.
module typed_point_table_nearest #(
   parameter int TABLE_DEPTH = 64,
   parameter int COORD_BITS  = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tptn_pkg::OP_W-1:0]            req_op,
   input  logic [tptn_pkg::KIND_W-1:0]          req_kind,
   input  logic [COORD_BITS-1:0]                req_x_pos,
   input  logic [COORD_BITS-1:0]                req_y_pos,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_success,
   output logic [tptn_pkg::RSP_INDEX_W-1:0]     rsp_result_index,
   output logic [tptn_pkg::RSP_COUNT_W-1:0]     rsp_entry_count,
   input  logic                                csr_write_enable,
   input  logic [tptn_pkg::LIMIT_W-1:0]         csr_write_data
);

   `include "typed_point_table_nearest_assert.svh"

   tptn_pkg::tptn_cmd_type    cmd;
   tptn_pkg::tptn_status_type status;

   // The controller sequences each request: capture, scan, drain, respond.
   tptn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the point store, the entry count, the limit register,
   // the compare pipeline and the output register.
   tptn_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_kind         (req_kind),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_success      (rsp_success),
      .rsp_result_index (rsp_result_index),
      .rsp_entry_count  (rsp_entry_count)
   );

   // A new request is only taken once the compare pipeline has drained.
   `TPTN_ASSERT_NOW(a_ready_pipe_empty, clock, reset, req_ready, !status.pipe_busy)
   // A response is only loaded when the output register is free.
   `TPTN_ASSERT_NOW(a_load_rsp_free, clock, reset, cmd.load_rsp, status.rsp_free)
   // Every entry read enters the compare pipeline.
   `TPTN_ASSERT_NEXT(a_read_enters_pipe, clock, reset, cmd.scan_step, status.pipe_busy)

endmodule
